// File: hw/rtl/pmi_pkg.sv
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared types, constants and fixed-point helpers for the particle motion
// integrator pipeline.
// ----------------------------------------------------------------------------
package pmi_pkg;

	localparam int DATA_W = 32;
	localparam int AXIS_W = 2;
	localparam int DRAG_W = 17;
	localparam int TS_W   = 21;
	localparam int INV_W  = 31;
	localparam int REP_W  = 4;
	// Wide enough to hold any repeat limit from one to sixteen.
	localparam int REPS_W = 5;
	localparam int ADDR_W = 4;
	localparam int PRDATA_W = 32;
	localparam int WIDE_W = 64;

	localparam int MAX_DRAG_REPEATS_DEF = 8;

	localparam logic [TS_W-1:0]  TS_RESET  = TS_W'(1092);
	localparam logic [INV_W-1:0] INV_RESET = INV_W'(3932160);
	localparam logic [REP_W-1:0] REP_RESET = REP_W'(1);

	localparam logic [AXIS_W-1:0] AXIS_VERTICAL = 2'd1;

	localparam logic [1:0] REG_TIME_STEP    = 2'd0;
	localparam logic [1:0] REG_INVERSE_STEP = 2'd1;
	localparam logic [1:0] REG_DRAG_REPEATS = 2'd2;

	typedef struct packed {
		logic [AXIS_W-1:0]        axis;
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] velocity;
		logic signed [DATA_W-1:0] rotation;
		logic signed [DATA_W-1:0] rotation_rate;
		logic signed [DATA_W-1:0] gravity_accel;
		logic [DRAG_W-1:0]        drag_factor;
	} in_item_t;

	typedef struct packed {
		logic [AXIS_W-1:0]        axis_out;
		logic signed [DATA_W-1:0] new_position;
		logic signed [DATA_W-1:0] new_velocity;
		logic signed [DATA_W-1:0] new_rotation;
	} out_item_t;

	// State of one item as it moves down the pipeline.
	typedef struct packed {
		logic [AXIS_W-1:0]        axis;
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] v0;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] new_rot;
		logic [DRAG_W-1:0]        drag;
		logic [REPS_W-1:0]        reps;
	} work_t;

	// Arithmetic right shift rounded to nearest, halves away from zero.
	function automatic logic signed [WIDE_W-1:0] round_shift(
		input logic signed [WIDE_W-1:0] p,
		input int unsigned sh
	);
		logic signed [WIDE_W-1:0] bias;
		bias = WIDE_W'(64'sd1 <<< (sh - 1));
		if (p < 0) begin
			bias = bias - WIDE_W'(64'sd1);
		end
		return (p + bias) >>> sh;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
		lo = -hi - WIDE_W'(64'sd1);
		if (v > hi) begin
			return DATA_W'(hi);
		end else if (v < lo) begin
			return DATA_W'(lo);
		end
		return DATA_W'(v);
	endfunction

endpackage

// File: hw/rtl/pmi_front.sv
// ----------------------------------------------------------------------------
// pmi_front
// Two-stage entry: gravity and rotation products, then the gravity add on
// the vertical axis and the saturated rotation update.
// ----------------------------------------------------------------------------
module pmi_front import pmi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  in_item_t          item,
	input  logic [REPS_W-1:0] reps,
	input  logic [TS_W-1:0]   ts,
	output logic              out_valid,
	output work_t             out_work
);

	localparam int GPROD_W = DATA_W + TS_W + 1;

	logic                      valid_s1;
	work_t                     work_s1;
	logic                      vertical_s1;
	logic signed [GPROD_W-1:0] gprod_s1;
	logic signed [GPROD_W-1:0] rprod_s1;
	logic                      valid_s2;
	work_t                     work_s2;
	work_t                     work_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1.axis     <= item.axis;
			work_s1.position <= item.position;
			work_s1.v0       <= item.velocity;
			work_s1.v        <= item.velocity;
			work_s1.new_rot  <= item.rotation;
			work_s1.drag     <= item.drag_factor;
			work_s1.reps     <= reps;
			vertical_s1      <= (item.axis == AXIS_VERTICAL);
			gprod_s1         <= $signed(item.gravity_accel) * $signed({1'b0, ts});
			rprod_s1         <= $signed(item.rotation_rate) * $signed({1'b0, ts});
		end
	end

	always_comb begin
		work_next         = work_s1;
		work_next.new_rot = sat32(WIDE_W'(work_s1.new_rot)
			+ round_shift(WIDE_W'(rprod_s1), 16));
		if (vertical_s1) begin
			work_next.v = sat32(WIDE_W'(work_s1.v0)
				+ round_shift(WIDE_W'(gprod_s1), 16));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s2 <= work_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_work  = work_s2;

endmodule

// File: hw/rtl/pmi_drag_stage.sv
// ----------------------------------------------------------------------------
// pmi_drag_stage
// One drag repeat: multiply velocity by the drag factor, then round and
// saturate. The stage passes velocity through when its repeat is not used.
// ----------------------------------------------------------------------------
module pmi_drag_stage import pmi_pkg::*; #(
	parameter int STAGE_IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  work_t in_work,
	output logic  out_valid,
	output work_t out_work
);

	localparam int DPROD_W = DATA_W + DRAG_W + 1;

	logic                      valid_s1;
	work_t                     work_s1;
	logic signed [DPROD_W-1:0] prod_s1;
	logic                      valid_s2;
	work_t                     work_s2;
	logic                      active;
	work_t                     work_next;

	assign active = (work_s1.reps > REPS_W'(STAGE_IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		work_next = work_s1;
		if (active) begin
			work_next.v = sat32(round_shift(WIDE_W'(prod_s1), 16));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= in_work;
			prod_s1 <= $signed(in_work.v) * $signed({1'b0, in_work.drag});
			work_s2 <= work_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_work  = work_s2;

endmodule

// File: hw/rtl/pmi_tail.sv
// ----------------------------------------------------------------------------
// pmi_tail
// Acceleration, half-step term and position update, seven register stages
// ending in the result register.
// ----------------------------------------------------------------------------
module pmi_tail import pmi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  work_t            in_work,
	input  logic [TS_W-1:0]  ts,
	input  logic [INV_W-1:0] inv,
	output logic             out_valid,
	output out_item_t        out_item
);

	localparam int DV_W    = DATA_W + 1;
	localparam int HPROD_W = DATA_W + TS_W + 1;
	localparam int SUM_W   = DATA_W + 6;
	localparam int SPROD_W = SUM_W + TS_W + 1;
	localparam int NSTG    = 7;

	logic [NSTG-1:0]           valid_q;
	work_t                     work_s1, work_s2, work_s3, work_s4, work_s5, work_s6;
	logic signed [DV_W-1:0]    dv_s1;
	logic signed [WIDE_W-1:0]  aprod_s2;
	logic signed [DATA_W-1:0]  accel_s3;
	logic signed [HPROD_W-1:0] hprod_s4;
	logic signed [SUM_W-1:0]   sum_s5;
	logic signed [SPROD_W-1:0] sprod_s6;
	out_item_t                 result_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NSTG-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1  <= in_work;
			dv_s1    <= DV_W'(in_work.v) - DV_W'(in_work.v0);

			work_s2  <= work_s1;
			aprod_s2 <= WIDE_W'($signed(dv_s1) * $signed({1'b0, inv}));

			work_s3  <= work_s2;
			accel_s3 <= sat32(round_shift(aprod_s2, 16));

			work_s4  <= work_s3;
			hprod_s4 <= $signed(accel_s3) * $signed({1'b0, ts});

			// The sum of old velocity and the half term is kept exact.
			work_s5  <= work_s4;
			sum_s5   <= SUM_W'(WIDE_W'(work_s4.v0) + round_shift(WIDE_W'(hprod_s4), 17));

			work_s6  <= work_s5;
			sprod_s6 <= $signed(sum_s5) * $signed({1'b0, ts});

			result_s7.axis_out     <= work_s6.axis;
			result_s7.new_position <= sat32(WIDE_W'(work_s6.position)
				+ round_shift(WIDE_W'(sprod_s6), 16));
			result_s7.new_velocity <= work_s6.v;
			result_s7.new_rotation <= work_s6.new_rot;
		end
	end

	assign out_valid = valid_q[NSTG-1];
	assign out_item  = result_s7;

endmodule

// File: hw/rtl/particle_motion_integrator.sv
// ----------------------------------------------------------------------------
// particle_motion_integrator
// Semi-implicit Euler step with drag for one particle axis, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while no waiting result is held by
// result_stall; every drag repeat owns a multiply stage and a round stage, so
// the repeat count never slows the stream.
// The whole pipeline holds while a result waits under stall.
// Reset clears the valid bits and loads the register defaults.
module particle_motion_integrator import pmi_pkg::*; #(
	parameter int MAX_DRAG_REPEATS = MAX_DRAG_REPEATS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  in_item_t            item,
	output logic                result_valid,
	input  logic                result_stall,
	output out_item_t           result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [PRDATA_W-1:0] pwdata,
	output logic [PRDATA_W-1:0] prdata,
	output logic                pready
);

	logic [TS_W-1:0]   time_step_q;
	logic [INV_W-1:0]  inverse_step_q;
	logic [REP_W-1:0]  drag_repeats_q;
	logic [REPS_W-1:0] reps_clamped;
	logic [1:0]        reg_idx;
	logic              cfg_write;
	logic              en;

	work_t             drag_work  [0:MAX_DRAG_REPEATS];
	logic [MAX_DRAG_REPEATS:0] drag_valid;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q    <= TS_RESET;
			inverse_step_q <= INV_RESET;
			drag_repeats_q <= REP_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_TIME_STEP:    time_step_q    <= pwdata[TS_W-1:0];
				REG_INVERSE_STEP: inverse_step_q <= pwdata[INV_W-1:0];
				REG_DRAG_REPEATS: drag_repeats_q <= pwdata[REP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TIME_STEP:    prdata = PRDATA_W'(time_step_q);
			REG_INVERSE_STEP: prdata = PRDATA_W'(inverse_step_q);
			REG_DRAG_REPEATS: prdata = PRDATA_W'(drag_repeats_q);
			default:          prdata = '0;
		endcase
	end

	assign reps_clamped = (REPS_W'(drag_repeats_q) > REPS_W'(MAX_DRAG_REPEATS))
		? REPS_W'(MAX_DRAG_REPEATS) : REPS_W'(drag_repeats_q);

	// Every stage advances unless the result register holds a stalled transfer.
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	pmi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.item      (item),
		.reps      (reps_clamped),
		.ts        (time_step_q),
		.out_valid (drag_valid[0]),
		.out_work  (drag_work[0])
	);

	for (genvar k = 0; k < MAX_DRAG_REPEATS; k++) begin : g_drag
		pmi_drag_stage #(
			.STAGE_IDX (k)
		) u_drag (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (drag_valid[k]),
			.in_work   (drag_work[k]),
			.out_valid (drag_valid[k+1]),
			.out_work  (drag_work[k+1])
		);
	end

	pmi_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (drag_valid[MAX_DRAG_REPEATS]),
		.in_work   (drag_work[MAX_DRAG_REPEATS]),
		.ts        (time_step_q),
		.inv       (inverse_step_q),
		.out_valid (result_valid),
		.out_item  (result)
	);

endmodule

// File: hw/rtl/pmi_checker.sv
// ----------------------------------------------------------------------------
// pmi_checker
// Port-level checks on the particle motion integrator, bound to the top.
// ----------------------------------------------------------------------------
module pmi_checker import pmi_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input in_item_t            item,
	input logic                result_valid,
	input logic                result_stall,
	input out_item_t           result,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [ADDR_W-1:0]   paddr,
	input logic [PRDATA_W-1:0] pwdata,
	input logic [PRDATA_W-1:0] prdata,
	input logic                pready
);

	// A stalled result transfer must stay offered unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// A stalled input transfer stays offered unchanged.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("input item changed or dropped while stalled");

	// With an empty result register the block never refuses an input transfer.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled while no result is waiting");

	// A drag repeat count written over the bus reads back on a read that directly follows the write.
	a_drag_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[3:2] == REG_DRAG_REPEATS)
		##1 (psel && !pwrite && paddr[3:2] == REG_DRAG_REPEATS)
		|-> prdata[REP_W-1:0] == $past(pwdata[REP_W-1:0]))
		else $error("drag repeat register did not read back");

endmodule

bind particle_motion_integrator pmi_checker u_pmi_checker (.*);

// File: dv/motion_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_result_checker
// Watches the item, result and register channels of the particle motion
// integrator. It keeps its own copy of the registers, works out the update of
// every accepted item and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module motion_result_checker import pmi_pkg::*; #(
	parameter int MAX_DRAG_REPEATS = MAX_DRAG_REPEATS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  in_item_t            item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  out_item_t           result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [PRDATA_W-1:0] pwdata,
	output int                  error_count,
	output int                  updates_pending
);

	localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Q16_MIN = -Q16_MAX - 1;
	localparam int PRINT_LIMIT = 100;

	logic [TS_W-1:0]  step_q;
	logic [INV_W-1:0] inv_step_q;
	logic [REP_W-1:0] repeats_q;
	out_item_t        predicted_updates[$];
	out_item_t        oldest;

	task automatic report_error(input string msg);
		if (error_count < PRINT_LIMIT) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	// Product shifted right by sh, rounded to nearest with halves away from zero.
	function automatic longint scale_round(input longint a, input longint unsigned b,
			input int unsigned sh);
		logic [63:0] mag;
		logic [63:0] rounded;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		rounded = (mag * b + (64'd1 << (sh - 1))) >> sh;
		return (a < 0) ? -longint'(rounded) : longint'(rounded);
	endfunction

	function automatic longint saturate_q16(input longint v);
		if (v > Q16_MAX) begin
			return Q16_MAX;
		end
		if (v < Q16_MIN) begin
			return Q16_MIN;
		end
		return v;
	endfunction

	function automatic out_item_t integrate_axis(input in_item_t it);
		longint v0;
		longint vel;
		longint accel;
		longint half_term;
		longint total;
		int unsigned passes;
		int unsigned k;
		out_item_t upd;
		v0 = $signed(it.velocity);
		vel = v0;
		passes = (repeats_q > MAX_DRAG_REPEATS) ? MAX_DRAG_REPEATS : repeats_q;
		// Gravity only acts on the vertical axis; the unused axis code counts as horizontal.
		if (it.axis == AXIS_VERTICAL) begin
			vel = saturate_q16(vel + scale_round($signed(it.gravity_accel), step_q, 16));
		end
		for (k = 0; k < passes; k++) begin
			vel = saturate_q16(scale_round(vel, it.drag_factor, 16));
		end
		accel = saturate_q16(scale_round(vel - v0, inv_step_q, 16));
		// Half of accel times step is a single shift by 17, and the sum stays exact.
		half_term = scale_round(accel, step_q, 17);
		total = v0 + half_term;
		upd.axis_out = it.axis;
		upd.new_position = 32'(saturate_q16($signed(it.position)
			+ scale_round(total, step_q, 16)));
		upd.new_velocity = 32'(vel);
		upd.new_rotation = 32'(saturate_q16($signed(it.rotation)
			+ scale_round($signed(it.rotation_rate), step_q, 16)));
		return upd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= TS_RESET;
			inv_step_q <= INV_RESET;
			repeats_q <= REP_RESET;
			predicted_updates.delete();
			updates_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_TIME_STEP: step_q <= pwdata[TS_W-1:0];
					REG_INVERSE_STEP: inv_step_q <= pwdata[INV_W-1:0];
					REG_DRAG_REPEATS: repeats_q <= pwdata[REP_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				predicted_updates.push_back(integrate_axis(item));
			end
			if (result_valid && !result_stall) begin
				if (predicted_updates.size() == 0) begin
					report_error("result transfer with no update pending");
				end else begin
					oldest = predicted_updates.pop_front();
					if (result.axis_out !== oldest.axis_out) begin
						report_error($sformatf("axis_out got %0d expected %0d",
							result.axis_out, oldest.axis_out));
					end
					if (result.new_position !== oldest.new_position) begin
						report_error($sformatf("new_position got %0d expected %0d",
							$signed(result.new_position), $signed(oldest.new_position)));
					end
					if (result.new_velocity !== oldest.new_velocity) begin
						report_error($sformatf("new_velocity got %0d expected %0d",
							$signed(result.new_velocity), $signed(oldest.new_velocity)));
					end
					if (result.new_rotation !== oldest.new_rotation) begin
						report_error($sformatf("new_rotation got %0d expected %0d",
							$signed(result.new_rotation), $signed(oldest.new_rotation)));
					end
				end
			end
			updates_pending <= predicted_updates.size();
		end
	end

endmodule

// File: dv/tb_particle_motion_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_motion_integrator
// Drives particle axes through the integrator under several register settings,
// with random gaps on the item side and random stalls on the result side.
// The checker beside the block predicts and compares every update.
// ----------------------------------------------------------------------------
module tb_particle_motion_integrator;
	import pmi_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 55;
	localparam int PHASES = 9;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
	localparam logic [AXIS_W-1:0] AXIS_UNUSED = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic [DRAG_W-1:0] DRAG_ONE = 17'd65536;
	localparam logic [DRAG_W-1:0] DRAG_TOP = 17'h1FFFF;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid;
	logic                item_stall;
	in_item_t            item;
	logic                result_valid;
	logic                result_stall = 1'b0;
	out_item_t           result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [PRDATA_W-1:0] pwdata;
	logic [PRDATA_W-1:0] prdata;
	logic                pready;

	int error_count;
	int updates_pending;
	int tx_idle_pct = 35;
	int rx_idle_pct = 71;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	particle_motion_integrator uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	motion_result_checker u_result_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.error_count(error_count), .updates_pending(updates_pending)
	);

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Ends the run when nothing has moved on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || psel || (item_valid && !item_stall)
				|| (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic in_item_t make_item(input logic [AXIS_W-1:0] axis,
			input logic signed [31:0] pos, input logic signed [31:0] vel,
			input logic signed [31:0] rot, input logic signed [31:0] rate,
			input logic signed [31:0] grav, input logic [DRAG_W-1:0] drag);
		in_item_t it;
		it.axis = axis;
		it.position = pos;
		it.velocity = vel;
		it.rotation = rot;
		it.rotation_rate = rate;
		it.gravity_accel = grav;
		it.drag_factor = drag;
		return it;
	endfunction

	// Mostly moderate magnitudes so that saturation does not hide the arithmetic.
	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2, 3: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(4, 28);
		endcase
	endfunction

	function automatic logic [DRAG_W-1:0] rand_drag();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DRAG_ONE;
			2: return DRAG_W'($urandom_range(65537, 131071));
			default: return DRAG_W'($urandom_range(40000, 65536));
		endcase
	endfunction

	function automatic in_item_t rand_item();
		logic [AXIS_W-1:0] axis;
		axis = ($urandom_range(0, 9) == 0) ? AXIS_UNUSED : AXIS_W'($urandom_range(0, 2));
		return make_item(axis, rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
			rand_drag());
	endfunction

	task automatic send_update(input in_item_t it);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic wait_for_updates();
		item_valid <= 1'b0;
		do @(posedge clk); while (updates_pending != 0);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// A wait with psel low keeps the next setup phase apart from this access.
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [31:0] step, input logic [31:0] inv,
			input logic [31:0] reps);
		write_register(REG_TIME_STEP, step);
		write_register(REG_INVERSE_STEP, inv);
		write_register(REG_DRAG_REPEATS, reps);
	endtask

	task automatic send_random(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			// Now and then hold the stream until the pipeline has emptied.
			if ($urandom_range(0, 39) == 0) begin
				wait_for_updates();
			end
			send_update(rand_item());
		end
	endtask

	initial begin
		int phase;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset register values.
		send_update(make_item(AXIS_X, 0, 0, 0, 0, 0, DRAG_ONE));
		send_update(make_item(AXIS_VERTICAL, 0, 0, 0, 0, -32'sd642908, DRAG_ONE));
		send_update(make_item(AXIS_Z, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, DRAG_ONE));
		send_update(make_item(AXIS_VERTICAL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, DRAG_ONE));
		send_update(make_item(AXIS_X, Q_MIN, Q_MIN, 0, Q_MIN, 0, '0));
		send_update(make_item(AXIS_UNUSED, 0, 32'sd1000, 0, 0, Q_MAX, 17'd32768));
		send_update(make_item(AXIS_VERTICAL, 0, Q_MAX, 0, 0, Q_MAX, DRAG_TOP));
		send_update(make_item(AXIS_VERTICAL, 0, Q_MIN, 0, 0, Q_MIN, DRAG_TOP));
		send_update(make_item(AXIS_X, 0, 32'sh4000_0000, 0, 0, 0, DRAG_TOP));
		send_update(make_item(AXIS_Z, 0, -32'sd1, 0, 0, 0, 17'd1));
		send_update(make_item(AXIS_VERTICAL, 0, 32'sd1, 0, 0, -32'sd1, 17'd32768));
		send_update(make_item(AXIS_X, 32'sd6553600, 32'sd196608, 0, 32'sd131072, 0,
			17'd64880));
		send_update(make_item(AXIS_UNUSED, 0, Q_MIN, 0, 0, 0, DRAG_ONE));
		send_update(make_item(AXIS_VERTICAL, 0, 0, 0, 0, 32'sd1, '0));
		send_update(make_item(AXIS_Z, Q_MAX, 0, 32'sh7FFF_0000, Q_MAX, 0, DRAG_ONE));
		send_update(make_item(AXIS_X, 0, 0, Q_MIN, Q_MIN, 0, 17'h0AAAA));
		send_update(make_item(AXIS_Z, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh5555_5555, 17'h15555));

		for (phase = 0; phase < PHASES; phase++) begin
			wait_for_updates();
			if (phase == 3) begin
				tx_idle_pct = 71;
				rx_idle_pct = 35;
			end else if (phase == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (phase)
				0: ;
				1: set_registers(0, 0, 0);
				2: set_registers(1048576, 65536, MAX_DRAG_REPEATS_DEF);
				// All ones: each register keeps only the bits that it has.
				3: set_registers('1, '1, '1);
				4: set_registers(1092, 3932160, 9);
				default: set_registers($urandom_range(0, 1 << $urandom_range(6, 20)),
					$urandom & ((32'd1 << $urandom_range(10, 31)) - 1),
					$urandom_range(0, 10));
			endcase
			send_random(PHASE_ITEMS);
		end

		wait_for_updates();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && updates_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
